FILE: design/ltos_pkg.sv
`default_nettype none

package ltos_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Input item
    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  node_id;
        logic [31:0] timestamp;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic       done_res;
        logic       full_reject;
        logic       own_is_oldest;
        logic [4:0] entry_total;
    } out_item_t;

    // One table entry
    typedef struct packed {
        logic [7:0]  node_id;
        logic [31:0] stamp;
    } tbl_entry_t;

    // Table access request: one write and one read address per cycle
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        tbl_entry_t       wdata;
        logic [IDX_W-1:0] raddr;
    } tbl_req_t;

    // Compare unit outputs
    typedef struct packed {
        logic id_match;
        logic stamp_less;
    } cmp_res_t;

endpackage

`default_nettype wire

FILE: design/ltos_table.sv
`default_nettype none

module ltos_table (
    input  wire logic                clk,
    input  wire ltos_pkg::tbl_req_t  req,
    output ltos_pkg::tbl_entry_t     rd_data
);

    ltos_pkg::tbl_entry_t mem [ltos_pkg::TABLE_DEPTH];
    ltos_pkg::tbl_entry_t rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/ltos_cmp.sv
`default_nettype none

module ltos_cmp (
    input  wire ltos_pkg::tbl_entry_t entry,
    input  wire logic [7:0]           key_id,
    input  wire logic [31:0]          best_stamp,
    output ltos_pkg::cmp_res_t        res
);

    // Shared compare: id equality for lookup, unsigned less-than for the minimum search
    always_comb
    begin
        res.id_match   = (entry.node_id == key_id);
        res.stamp_less = (entry.stamp < best_stamp);
    end

endmodule

`default_nettype wire

FILE: design/ltos_seq.sv
`default_nettype none

module ltos_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_busy,
    input  wire ltos_pkg::in_item_t   in_item,
    input  wire logic [7:0]           own_id,
    output logic                      res_valid,
    input  wire logic                 res_take,
    output ltos_pkg::out_item_t       res_item,
    output ltos_pkg::tbl_req_t        req,
    input  wire ltos_pkg::tbl_entry_t rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [1:0]                     op_reg, op_next;
    logic [7:0]                     id_reg, id_next;
    logic [31:0]                    stamp_reg, stamp_next;
    logic [ltos_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [ltos_pkg::CNT_W-1:0]     issue_reg, issue_next;
    logic                           pend_reg, pend_next;
    logic [ltos_pkg::IDX_W-1:0]     ridx_reg, ridx_next;
    logic [31:0]                    best_stamp_reg, best_stamp_next;
    logic [7:0]                     best_id_reg, best_id_next;
    ltos_pkg::out_item_t            res_reg, res_next;
    ltos_pkg::cmp_res_t             cmp;
    logic                           issue_more;
    logic                           stream_end;

    ltos_cmp u_cmp (
        .entry      (rd_data),
        .key_id     (id_reg),
        .best_stamp (best_stamp_reg),
        .res        (cmp)
    );

    assign issue_more = (issue_reg < count_reg);
    assign stream_end = !pend_reg && !issue_more;

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        stamp_next      = stamp_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        ridx_next       = ridx_reg;
        best_stamp_next = best_stamp_reg;
        best_id_next    = best_id_reg;
        res_next        = res_reg;
        req.we          = 1'b0;
        req.waddr       = ridx_reg - 1'b1;
        req.wdata       = rd_data;
        req.raddr       = issue_reg[ltos_pkg::IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_item.opcode;
                    id_next    = in_item.node_id;
                    stamp_next = in_item.timestamp;
                    issue_next = '0;
                    if (in_item.opcode == ltos_pkg::OP_CLEAR)
                    begin
                        count_next           = '0;
                        res_next.done_res      = 1'b0;
                        res_next.full_reject   = 1'b0;
                        res_next.own_is_oldest = 1'b0;
                        res_next.entry_total   = 5'd0;
                        state_next           = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                res_next.done_res      = 1'b0;
                res_next.full_reject   = 1'b0;
                res_next.own_is_oldest = 1'b0;
                res_next.entry_total   = 5'(count_reg);

                // running minimum, earliest entry wins ties
                if (op_reg == ltos_pkg::OP_QUERY && pend_reg &&
                    (ridx_reg == '0 || cmp.stamp_less))
                begin
                    best_stamp_next = rd_data.stamp;
                    best_id_next    = rd_data.node_id;
                end

                if (op_reg != ltos_pkg::OP_QUERY && pend_reg && cmp.id_match)
                begin
                    if (op_reg == ltos_pkg::OP_REMOVE)
                    begin
                        issue_next = ltos_pkg::CNT_W'(ridx_reg) + 1'b1;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        // duplicate insert keeps its old stamp
                        state_next = S_DONE;
                    end
                end
                else if (stream_end)
                begin
                    if (op_reg == ltos_pkg::OP_INSERT)
                    begin
                        if (count_reg >= ltos_pkg::CNT_W'(ltos_pkg::TABLE_DEPTH))
                        begin
                            res_next.full_reject = 1'b1;
                        end
                        else
                        begin
                            req.we               = 1'b1;
                            req.waddr            = count_reg[ltos_pkg::IDX_W-1:0];
                            req.wdata.node_id    = id_reg;
                            req.wdata.stamp      = stamp_reg;
                            count_next           = count_reg + 1'b1;
                            res_next.done_res    = 1'b1;
                            res_next.entry_total = 5'(count_reg + 1'b1);
                        end
                    end
                    else if (op_reg == ltos_pkg::OP_QUERY)
                    begin
                        res_next.own_is_oldest = (count_reg != '0) && (best_id_reg == own_id);
                    end
                    state_next = S_DONE;
                end
                else if (issue_more)
                begin
                    issue_next = issue_reg + 1'b1;
                    pend_next  = 1'b1;
                    ridx_next  = issue_reg[ltos_pkg::IDX_W-1:0];
                end
            end

            S_SHIFT:
            begin
                // entry arriving from slot k moves down to slot k-1
                if (pend_reg)
                begin
                    req.we = 1'b1;
                end

                if (stream_end)
                begin
                    count_next             = count_reg - 1'b1;
                    res_next.done_res      = 1'b1;
                    res_next.full_reject   = 1'b0;
                    res_next.own_is_oldest = 1'b0;
                    res_next.entry_total   = 5'(count_reg - 1'b1);
                    state_next             = S_DONE;
                end
                else if (issue_more)
                begin
                    issue_next = issue_reg + 1'b1;
                    pend_next  = 1'b1;
                    ridx_next  = issue_reg[ltos_pkg::IDX_W-1:0];
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_reg       <= pend_next;
            op_reg         <= op_next;
            id_reg         <= id_next;
            stamp_reg      <= stamp_next;
            issue_reg      <= issue_next;
            ridx_reg       <= ridx_next;
            best_stamp_reg <= best_stamp_next;
            best_id_reg    <= best_id_next;
            res_reg        <= res_next;
        end
    end

    assign in_busy   = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_item  = res_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ltos_pkg::CNT_W'(ltos_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |-> (state_reg == S_SCAN || state_reg == S_SHIFT))
        else $error("table write outside scan or shift");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !(res_reg.done_res && res_reg.full_reject))
        else $error("done and full reject both set");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> $stable(count_reg))
        else $error("entry count moved while result waits");

    a_total_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (res_reg.entry_total == 5'(count_reg)))
        else $error("reported total differs from entry count");

endmodule

`default_nettype wire

FILE: design/leader_table_oldest_select_unit.sv
`default_nettype none

// Table of up to 16 node ids with request stamps, kept in insertion order.
// Ops: insert (no duplicates, rejected and flagged when full), remove (later
// entries shift down), query (is own_id on the entry with the smallest stamp,
// earliest wins ties), clear. One item in flight at a time; the table is a
// single-port-read memory scanned one entry per cycle by a shared compare unit.
// Clear goes straight to its result; query, insert and a remove that misses scan
// all n entries; a duplicate insert stops at the slot where it matches; a remove
// that hits looks up entries up to the match, then shifts each later entry down
// one slot. The result reaches out_valid in the same cycle that in_stall drops
// and the next item can be taken. A waiting result
// sits in an output register and the next item is taken meanwhile. own_id is
// written through the cfg port, which is always ready and must be used only while
// the block is idle.
module leader_table_oldest_select_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ltos_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ltos_pkg::out_item_t      out_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);

    logic [7:0]           own_id_reg;
    logic                 out_valid_reg;
    ltos_pkg::out_item_t  out_item_reg;
    logic                 seq_busy;
    logic                 res_valid;
    logic                 res_take;
    ltos_pkg::out_item_t  res_item;
    ltos_pkg::tbl_req_t   req;
    ltos_pkg::tbl_entry_t rd_data;

    ltos_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_busy   (seq_busy),
        .in_item   (in_item),
        .own_id    (own_id_reg),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_item  (res_item),
        .req       (req),
        .rd_data   (rd_data)
    );

    ltos_table u_table (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    // Config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            own_id_reg <= cfg_data;
        end
    end

    // Output register: loads when empty or being drained
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
            out_item_reg  <= res_item;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign in_stall  = seq_busy;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

FILE: test/tb_leader_table_oldest_select_unit.sv
`default_nettype none

module tb_leader_table_oldest_select_unit;

    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int POOL_SIZE      = 20;
    localparam int LONG_HOLD      = 60;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    ltos_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_stall;
    ltos_pkg::out_item_t out_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [7:0]          cfg_data;

    // Predictor state: table copy and own id
    logic [7:0]  tbl_ids    [ltos_pkg::TABLE_DEPTH];
    logic [31:0] tbl_stamps [ltos_pkg::TABLE_DEPTH];
    int          tbl_count;
    logic [7:0]  own_id_model;

    // Expected status items, oldest first
    ltos_pkg::out_item_t expected_status_q [$];
    int                  mismatch_count;

    // Stimulus knobs
    logic       send_gaps_on;
    logic       recv_gaps_on;
    int         long_hold_req;
    logic [7:0] id_pool [POOL_SIZE];

    leader_table_oldest_select_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one table operation to the predictor and return its status
    function automatic ltos_pkg::out_item_t predict_table_op(input ltos_pkg::in_item_t op_item);
        ltos_pkg::out_item_t res;
        int                  slot;
        int                  best;
        int                  i;
        res  = '0;
        slot = -1;
        for (i = 0; i < tbl_count; i++)
        begin
            if (slot < 0 && tbl_ids[i] == op_item.node_id)
                slot = i;
        end
        case (op_item.opcode)
            ltos_pkg::OP_INSERT:
            begin
                if (slot < 0)
                begin
                    if (tbl_count >= ltos_pkg::TABLE_DEPTH)
                        res.full_reject = 1'b1;
                    else
                    begin
                        tbl_ids[tbl_count]    = op_item.node_id;
                        tbl_stamps[tbl_count] = op_item.timestamp;
                        tbl_count++;
                        res.done_res = 1'b1;
                    end
                end
            end
            ltos_pkg::OP_REMOVE:
            begin
                if (slot >= 0)
                begin
                    for (i = slot; i + 1 < tbl_count; i++)
                    begin
                        tbl_ids[i]    = tbl_ids[i + 1];
                        tbl_stamps[i] = tbl_stamps[i + 1];
                    end
                    tbl_count--;
                    res.done_res = 1'b1;
                end
            end
            ltos_pkg::OP_QUERY:
            begin
                if (tbl_count > 0)
                begin
                    best = 0;
                    // strict less: earliest entry wins a tie
                    for (i = 1; i < tbl_count; i++)
                    begin
                        if (tbl_stamps[i] < tbl_stamps[best])
                            best = i;
                    end
                    res.own_is_oldest = (tbl_ids[best] == own_id_model);
                end
            end
            default:
                tbl_count = 0;
        endcase
        res.entry_total = 5'(tbl_count);
        return res;
    endfunction

    // Compare one accepted status item with the oldest expectation
    task automatic check_status_item(input ltos_pkg::out_item_t got);
        ltos_pkg::out_item_t want;
        if (expected_status_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatch_count++;
        end
        else
        begin
            want = expected_status_q.pop_front();
            if (got.done_res !== want.done_res)
            begin
                $display("%0t: done_res expected %b actual %b",
                         $time, want.done_res, got.done_res);
                mismatch_count++;
            end
            if (got.full_reject !== want.full_reject)
            begin
                $display("%0t: full_reject expected %b actual %b",
                         $time, want.full_reject, got.full_reject);
                mismatch_count++;
            end
            if (got.own_is_oldest !== want.own_is_oldest)
            begin
                $display("%0t: own_is_oldest expected %b actual %b",
                         $time, want.own_is_oldest, got.own_is_oldest);
                mismatch_count++;
            end
            if (got.entry_total !== want.entry_total)
            begin
                $display("%0t: entry_total expected %0d actual %0d",
                         $time, want.entry_total, got.entry_total);
                mismatch_count++;
            end
        end
    endtask

    // Receiver: check results, drive stall (bursts and long holds)
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                check_status_item(out_item);
            if (long_hold_req > 0)
            begin
                hold_left     = long_hold_req;
                long_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (recv_gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(1, 3) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: cycles with no accepted item on any channel
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Offer one item, wait for acceptance, record its expected status
    task automatic send_item(input ltos_pkg::in_item_t op_item);
        if (send_gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= op_item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_status_q.push_back(predict_table_op(op_item));
    endtask

    task automatic send_op(input logic [1:0] opcode, input logic [7:0] node_id,
                           input logic [31:0] stamp);
        ltos_pkg::in_item_t op_item;
        op_item.opcode    = opcode;
        op_item.node_id   = node_id;
        op_item.timestamp = stamp;
        send_item(op_item);
    endtask

    // Stop offering, wait for every result, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write own_id; call only while idle
    task automatic set_own_id(input logic [7:0] id_value);
        cfg_valid <= 1'b1;
        cfg_data  <= id_value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        own_id_model = id_value;
    endtask

    // Random op: ids mostly from a small pool so hits, dups and fills happen
    function automatic ltos_pkg::in_item_t random_table_op(input int clear_weight);
        ltos_pkg::in_item_t op_item;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < clear_weight)
            op_item.opcode = ltos_pkg::OP_CLEAR;
        else if (pick < clear_weight + 45)
            op_item.opcode = ltos_pkg::OP_INSERT;
        else if (pick < clear_weight + 70)
            op_item.opcode = ltos_pkg::OP_REMOVE;
        else
            op_item.opcode = ltos_pkg::OP_QUERY;
        if ($urandom_range(0, 9) < 8)
            op_item.node_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            op_item.node_id = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: op_item.timestamp = $urandom;
            1: op_item.timestamp = $urandom_range(0, 3);
            2: op_item.timestamp = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: op_item.timestamp = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                          16'($urandom)};
        endcase
        return op_item;
    endfunction

    task automatic run_random_phase(input int n_items, input int clear_weight,
                                    input logic [7:0] own_value);
        int k;
        drain_results();
        id_pool[0] = own_value;
        for (k = 1; k < POOL_SIZE; k++)
            id_pool[k] = 8'($urandom_range(0, 255));
        set_own_id(own_value);
        for (k = 0; k < n_items; k++)
            send_item(random_table_op(clear_weight));
    endtask

    // Empty table, absent remove, duplicate insert, extreme fields, clear
    task automatic test_basic_ops();
        send_op(ltos_pkg::OP_QUERY,  8'h00, 32'h0000_0000);
        send_op(ltos_pkg::OP_REMOVE, 8'h05, 32'hFFFF_FFFF);
        send_op(ltos_pkg::OP_INSERT, 8'h00, 32'hFFFF_FFFF);
        send_op(ltos_pkg::OP_INSERT, 8'hFF, 32'h0000_0000);
        send_op(ltos_pkg::OP_INSERT, 8'h00, 32'h0000_0000);
        send_op(ltos_pkg::OP_QUERY,  8'hFF, 32'hFFFF_FFFF);
        drain_results();
        set_own_id(8'hFF);
        send_op(ltos_pkg::OP_QUERY,  8'h00, 32'h0000_0000);
        send_op(ltos_pkg::OP_CLEAR,  8'hFF, 32'hFFFF_FFFF);
    endtask

    // Fill to capacity with tied stamps, reject a new id, dup into full table
    task automatic test_full_table();
        int i;
        drain_results();
        set_own_id(8'hA5);
        for (i = 0; i < ltos_pkg::TABLE_DEPTH; i++)
            send_op(ltos_pkg::OP_INSERT, 8'(8'hA5 + i * 8'h11), 32'h8000_0000);
        send_op(ltos_pkg::OP_INSERT, 8'h3C, 32'h0000_0001);
        send_op(ltos_pkg::OP_INSERT, 8'hA5, 32'h0000_0000);
        send_op(ltos_pkg::OP_QUERY,  8'h00, 32'h0000_0000);
        send_op(ltos_pkg::OP_REMOVE, 8'hA5, 32'h0000_0000);
    endtask

    // Receiver holds off long while the sender keeps offering items
    task automatic test_output_backpressure();
        int i;
        drain_results();
        send_gaps_on  = 1'b0;
        long_hold_req = LONG_HOLD;
        for (i = 0; i < 12; i++)
            send_item(random_table_op(3));
        send_gaps_on = 1'b1;
    endtask

    // Sender waits for all results mid-sequence, then resumes
    task automatic test_sender_pause();
        int i;
        for (i = 0; i < 20; i++)
            send_item(random_table_op(3));
        drain_results();
        for (i = 0; i < 20; i++)
            send_item(random_table_op(3));
    endtask

    task automatic test_random_mix();
        run_random_phase(260, 5, 8'h00);
        run_random_phase(260, 2, 8'hFF);
        run_random_phase(260, 8, 8'($urandom_range(0, 255)));
        run_random_phase(260, 1, 8'($urandom_range(0, 255)));
        run_random_phase(260, 3, 8'($urandom_range(0, 255)));
        run_random_phase(260, 5, 8'($urandom_range(0, 255)));
    endtask

    // Last stretch at full rate on both sides
    task automatic test_final_no_idle();
        drain_results();
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
        run_random_phase(240, 3, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = 8'h00;
        tbl_count      = 0;
        own_id_model   = 8'h00;
        mismatch_count = 0;
        send_gaps_on   = 1'b1;
        recv_gaps_on   = 1'b1;
        long_hold_req  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_full_table();
        test_output_backpressure();
        test_sender_pause();
        test_random_mix();
        test_final_no_idle();

        drain_results();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: leader_table_oldest_select_unit.f
design/ltos_pkg.sv
design/ltos_table.sv
design/ltos_cmp.sv
design/ltos_seq.sv
design/leader_table_oldest_select_unit.sv
test/tb_leader_table_oldest_select_unit.sv
